// ===== rtl/rpfa_pkg.sv =====
// Shared types and codes for the randomized page frame allocator.
package rpfa_pkg;

  localparam int unsigned ReqW  = 2;
  localparam int unsigned StW   = 3;
  localparam int unsigned AddrW = 32;
  localparam int unsigned RndW  = 31;
  localparam int unsigned CntW  = 7;

  typedef enum logic [1:0] {
    REQ_FREE  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_DUMP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADADDR  = 3'd2,
    ST_DUMPLONG = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_KERNEL_END = 1'b0,
    CFG_PHYS_TOP   = 1'b1
  } cfg_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request word
    logic free_push;  // write frame at head
    logic div_start;  // start remainder unit
    logic rd_slot;    // issue read of chosen slot
    logic cap_frame;  // capture read frame, record grant
    logic shift_rd;   // read slot+1 during removal
    logic shift_wr;   // write slot, advance
    logic dump_start; // init dump pointer
    logic dump_rd;    // read history entry
    logic emit;       // load output register
    logic [StW-1:0] emit_status;
    logic emit_addr;  // drive address from datapath
    logic emit_dump;  // use history data
    logic emit_last;
  } rpfa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ReqW-1:0] req;
    logic bad_addr;
    logic full;
    logic empty;
    logic dump_bad;
    logic dump_zero;
    logic div_done;
    logic shift_done;
    logic dump_last;
    logic out_busy;
  } rpfa_sts_t;

endpackage

// ===== rtl/rpfa_ctrl.sv =====
// Request sequencer for the page frame allocator.
module rpfa_ctrl
  import rpfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rpfa_sts_t sts_i,
  output rpfa_cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_DIV   = 11'b00000000100,
    S_RD    = 11'b00000001000,
    S_CAP   = 11'b00000010000,
    S_SHRD  = 11'b00000100000,
    S_SHWR  = 11'b00001000000,
    S_GRANT = 11'b00010000000,
    S_DRD   = 11'b00100000000,
    S_DWAIT = 11'b01000000000,
    S_DEMIT = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts_i.out_busy) begin
          state_d = S_IDLE;
          case (sts_i.req)
            REQ_FREE: begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (sts_i.bad_addr) cmd_o.emit_status = ST_BADADDR;
              else if (sts_i.full) cmd_o.emit_status = ST_FULL;
              else begin
                cmd_o.emit_status = ST_OK;
                cmd_o.free_push   = 1'b1;
              end
            end
            REQ_ALLOC: begin
              if (sts_i.empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                cmd_o.div_start = 1'b1;
                state_d         = S_DIV;
              end
            end
            REQ_DUMP: begin
              if (sts_i.dump_bad || sts_i.dump_zero) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_last   = 1'b1;
                cmd_o.emit_status = sts_i.dump_bad ? ST_DUMPLONG : ST_OK;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d          = S_DRD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_RD;
      S_RD: begin
        cmd_o.rd_slot = 1'b1;
        state_d       = S_CAP;
      end
      S_CAP: begin
        cmd_o.cap_frame = 1'b1;
        state_d         = S_SHRD;
      end
      S_SHRD: begin
        if (sts_i.shift_done) state_d = S_GRANT;
        else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHRD;
      end
      S_GRANT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_addr   = 1'b1;
          cmd_o.emit_status = ST_OK;
          state_d           = S_IDLE;
        end
      end
      S_DRD: begin
        cmd_o.dump_rd = 1'b1;
        state_d       = S_DWAIT;
      end
      S_DWAIT: state_d = S_DEMIT;
      S_DEMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_addr   = 1'b1;
          cmd_o.emit_dump   = 1'b1;
          cmd_o.emit_status = ST_OK;
          cmd_o.emit_last   = sts_i.dump_last;
          state_d           = sts_i.dump_last ? S_IDLE : S_DRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

// ===== rtl/rpfa_dp.sv =====
// Datapath: free list and history memories, remainder unit, output register.
module rpfa_dp
  import rpfa_pkg::*;
#(
  parameter int unsigned FRAME_CAPACITY = 4096,
  parameter int unsigned HISTORY_DEPTH  = 512,
  parameter int unsigned MAX_DUMP       = 64,
  parameter int unsigned PAGE_BITS      = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [AddrW-1:0] cfg_data_i,
  input  logic [ReqW-1:0]  req_i,
  input  logic [AddrW-1:0] page_addr_i,
  input  logic [RndW-1:0]  rnd_i,
  input  logic [CntW-1:0]  cnt_i,
  input  rpfa_cmd_t        cmd_i,
  output rpfa_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [StW-1:0]   out_status_o,
  output logic [AddrW-1:0] out_addr_o,
  output logic             out_last_o
);

  localparam int unsigned FrW = AddrW - PAGE_BITS;
  localparam int unsigned CW  = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned SW  = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
  localparam int unsigned HW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned GW  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned DivW = (RndW > CW) ? RndW : CW;
  localparam int unsigned BW  = $clog2(RndW + 1);

  logic [AddrW-1:0] kend_q, ptop_q;
  logic [ReqW-1:0]  req_q;
  logic [AddrW-1:0] addr_q;
  logic [RndW-1:0]  rnd_q;
  logic [CntW-1:0]  cnt_q;
  logic [CW-1:0]    fcnt_q;
  logic [HW-1:0]    hpos_q;
  logic [GW-1:0]    grec_q;

  logic [FrW-1:0] ff_mem [FRAME_CAPACITY];
  logic [FrW-1:0] hist_mem [HISTORY_DEPTH];
  logic [FrW-1:0] ff_rd_q, hist_rd_q, frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q <= AddrW'(32'h0010_0000);
      ptop_q <= AddrW'(32'h0100_0000);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_KERNEL_END) kend_q <= cfg_data_i;
      else ptop_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i;
      addr_q <= page_addr_i;
      rnd_q  <= rnd_i;
      cnt_q  <= cnt_i;
    end
  end

  // restoring remainder, one bit per cycle
  logic [DivW-1:0] rem_q;
  logic [RndW-1:0] quo_q;
  logic [BW-1:0]   bit_q;
  logic            div_busy_q;
  logic [DivW:0]   rem_sh;
  assign rem_sh = {rem_q, quo_q[RndW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      bit_q      <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      bit_q      <= BW'(RndW);
    end else if (div_busy_q) begin
      bit_q <= bit_q - 1'b1;
      if (bit_q == BW'(1)) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= rnd_q;
    end else if (div_busy_q) begin
      quo_q <= quo_q << 1;
      if (rem_sh >= (DivW+1)'(fcnt_q)) rem_q <= DivW'(rem_sh - (DivW+1)'(fcnt_q));
      else rem_q <= DivW'(rem_sh);
    end
  end

  // slot = count - 1 - pos; removal shifts entries above slot down by one
  logic [CW-1:0] slot_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_slot) slot_q <= fcnt_q - CW'(1) - CW'(rem_q);
    else if (cmd_i.shift_wr) slot_q <= slot_q + CW'(1);
  end

  logic [CW-1:0] ff_rd_addr;
  always_comb begin
    ff_rd_addr = fcnt_q - CW'(1) - CW'(rem_q);
    if (cmd_i.shift_rd) ff_rd_addr = slot_q + CW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_slot || cmd_i.shift_rd) ff_rd_q <= ff_mem[ff_rd_addr[SW-1:0]];
    if (cmd_i.free_push) ff_mem[fcnt_q[SW-1:0]] <= addr_q[AddrW-1:PAGE_BITS];
    else if (cmd_i.shift_wr) ff_mem[slot_q[SW-1:0]] <= ff_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_frame) frame_q <= ff_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fcnt_q <= '0;
    else if (cmd_i.free_push) fcnt_q <= fcnt_q + CW'(1);
    else if (cmd_i.cap_frame) fcnt_q <= fcnt_q - CW'(1);
  end

  // grant history ring
  logic [HW-1:0] dptr_q;
  logic [CntW-1:0] dleft_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_frame) hist_mem[hpos_q] <= ff_rd_q;
    if (cmd_i.dump_rd) hist_rd_q <= hist_mem[dptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q <= '0;
      grec_q <= '0;
    end else if (cmd_i.cap_frame) begin
      hpos_q <= (hpos_q == HW'(HISTORY_DEPTH - 1)) ? '0 : hpos_q + HW'(1);
      if (grec_q < GW'(HISTORY_DEPTH)) grec_q <= grec_q + GW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dump_start) begin
      dptr_q  <= (hpos_q == '0) ? HW'(HISTORY_DEPTH - 1) : hpos_q - HW'(1);
      dleft_q <= cnt_q;
    end else if (cmd_i.dump_rd) begin
      dptr_q  <= (dptr_q == '0) ? HW'(HISTORY_DEPTH - 1) : dptr_q - HW'(1);
      dleft_q <= dleft_q - CntW'(1);
    end
  end

  // output register
  logic [FrW-1:0] emit_frame;
  assign emit_frame = cmd_i.emit_dump ? hist_rd_q : frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_o <= cmd_i.emit_status;
      out_addr_o   <= cmd_i.emit_addr ? {emit_frame, PAGE_BITS'(0)} : '0;
      out_last_o   <= cmd_i.emit_last;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.req        = req_q;
    sts_o.bad_addr   = (addr_q[PAGE_BITS-1:0] != '0) || (addr_q < kend_q) ||
                       (addr_q >= ptop_q);
    sts_o.full       = (fcnt_q >= CW'(FRAME_CAPACITY));
    sts_o.empty      = (fcnt_q == '0);
    sts_o.dump_bad   = ({{GW{1'b0}}, cnt_q} > {{CntW{1'b0}}, grec_q}) ||
                       (cnt_q > CntW'(MAX_DUMP));
    sts_o.dump_zero  = (cnt_q == '0);
    sts_o.div_done   = !div_busy_q;
    sts_o.shift_done = (slot_q == fcnt_q);
    sts_o.dump_last  = (dleft_q == '0);
    sts_o.out_busy   = out_valid_o && !out_ready_i;
  end

endmodule

// ===== rtl/randomized_page_frame_allocator_top.sv =====
// Top level of the randomized page frame allocator.
// Usage: request words enter on s_axis (tdata = page_addr, random_value,
// dump_count; tuser = req_type). Results leave on m_axis (tdata = status,
// result_addr; tlast marks the final word of a request).
// One request is worked at a time; s_axis_tready is high only when idle.
// Free: the result word is loaded into the output register from the decode state.
// Alloc: time grows with the entries above the chosen slot and is set by the bit-serial
// remainder and the one-port free list memory, which moves one entry down per read and
// write state pair. Dump of n: n words, one history memory read per word.
// Empty/bad requests give a single status word. Unknown request types give no output.
// The user makes configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle;
// the block itself does not enforce this. Reset clears the free count, history position
// and record count and loads default bounds; memories are not cleared. When m_axis_tready
// is low the output register holds and the sequencer waits before emitting more.
module randomized_page_frame_allocator_top
  import rpfa_pkg::*;
#(
  parameter int unsigned FRAME_CAPACITY = 4096,
  parameter int unsigned HISTORY_DEPTH  = 512,
  parameter int unsigned MAX_DUMP       = 64,
  parameter int unsigned PAGE_BITS      = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // page_addr[31:0], random_value[62:32], dump_count[69:63]
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status[2:0], result_addr[34:3]
  output logic        m_axis_tlast
);

  rpfa_cmd_t cmd;
  rpfa_sts_t sts;
  logic [StW-1:0]   st;
  logic [AddrW-1:0] ra;

  rpfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpfa_dp #(
    .FRAME_CAPACITY(FRAME_CAPACITY), .HISTORY_DEPTH(HISTORY_DEPTH),
    .MAX_DUMP(MAX_DUMP), .PAGE_BITS(PAGE_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i        (s_axis_tuser),
    .page_addr_i  (s_axis_tdata[31:0]),
    .rnd_i        (s_axis_tdata[62:32]),
    .cnt_i        (s_axis_tdata[69:63]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (st),
    .out_addr_o   (ra),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, ra, st};

endmodule

// ===== rtl/rpfa_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
module rpfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
    else $error("status out of range");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != 3'd0) |-> m_axis_tlast)
    else $error("error status without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != 3'd0) |-> m_axis_tdata[34:3] == 32'd0)
    else $error("error status with address");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken while busy");

endmodule

bind randomized_page_frame_allocator_top rpfa_checker u_rpfa_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
